// File: hdl/sfr_pkg.sv
// sfr_pkg: types and constants for the serial frame receiver
// no dependencies; imported by sfr_parser and serial_frame_receiver_core
package sfr_pkg;

  localparam int BufSize = 64;
  localparam int LenLimit = BufSize - 8;

  localparam logic [7:0] HeadA = 8'hAA;
  localparam logic [7:0] HeadB = 8'h55;
  localparam logic [7:0] TailA = 8'h0D;
  localparam logic [7:0] TailB = 8'h0A;
  localparam logic [7:0] ControlTypeReset = 8'h02;

  typedef enum logic [3:0] {
    PhWaitHeadA = 4'd0,
    PhWaitHeadB = 4'd1,
    PhNode      = 4'd2,
    PhType      = 4'd3,
    PhLength    = 4'd4,
    PhPayload   = 4'd5,
    PhChecksum  = 4'd6,
    PhWaitTailA = 4'd7,
    PhWaitTailB = 4'd8
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] checksum_byte;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [7:0] frame_type;
    logic [7:0] node_id;
  } result_t;

endpackage

// File: hdl/sfr_parser.sv
// sfr_parser: frame phase machine and held frame fields
// depends on sfr_pkg; one byte per accepted item, result is combinational
module sfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       control_type_i,
  output sfr_pkg::result_t res_o
);
  import sfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] node_q, node_d;
  logic [7:0] type_q, type_d;
  logic [7:0] length_q, length_d;
  logic [7:0] first_q, first_d;
  logic [7:0] checksum_q, checksum_d;
  logic [7:0] left_dec;

  assign left_dec = bytes_left_q - 8'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (byte_en_i) begin
      unique case (phase_q)
        PhWaitHeadA: phase_d = (rx_byte_i == HeadA) ? PhWaitHeadB : PhWaitHeadA;
        PhWaitHeadB: phase_d = (rx_byte_i == HeadB) ? PhNode : PhWaitHeadA;
        PhNode:      phase_d = PhType;
        PhType:      phase_d = PhLength;
        PhLength: begin
          if (rx_byte_i == 8'd0) begin
            phase_d = PhChecksum;
          end else if ({1'b0, rx_byte_i} < 9'(LenLimit)) begin
            phase_d = PhPayload;
          end else begin
            phase_d = PhWaitHeadA;
          end
        end
        PhPayload:   phase_d = (left_dec == 8'd0) ? PhChecksum : PhPayload;
        PhChecksum:  phase_d = PhWaitTailA;
        PhWaitTailA: phase_d = (rx_byte_i == TailA) ? PhWaitTailB : PhWaitHeadA;
        PhWaitTailB: phase_d = PhWaitHeadA;
        default:     phase_d = PhWaitHeadA;
      endcase
    end
  end

  // held fields and result
  always_comb begin
    bytes_left_d = bytes_left_q;
    node_d       = node_q;
    type_d       = type_q;
    length_d     = length_q;
    first_d      = first_q;
    checksum_d   = checksum_q;
    res_o        = '0;
    res_o.node_id        = node_q;
    res_o.frame_type     = type_q;
    res_o.payload_length = length_q[5:0];
    res_o.command        = (type_q == control_type_i) ? first_q : 8'd0;
    res_o.checksum_byte  = checksum_q;
    if (byte_en_i) begin
      unique case (phase_q)
        PhNode: node_d = rx_byte_i;
        PhType: type_d = rx_byte_i;
        PhLength: begin
          length_d     = rx_byte_i;
          bytes_left_d = rx_byte_i;
        end
        PhPayload: begin
          if (bytes_left_q == length_q) begin
            first_d = rx_byte_i;
          end
          bytes_left_d = left_dec;
        end
        PhChecksum: begin
          checksum_d = rx_byte_i;
          if (length_q == 8'd0) begin
            first_d = rx_byte_i;
          end
        end
        PhWaitTailB: res_o.valid = (rx_byte_i == TailB);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhWaitHeadA;
      bytes_left_q <= 8'd0;
      node_q       <= 8'd0;
      type_q       <= 8'd0;
      length_q     <= 8'd0;
      first_q      <= 8'd0;
      checksum_q   <= 8'd0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      node_q       <= node_d;
      type_q       <= type_d;
      length_q     <= length_d;
      first_q      <= first_d;
      checksum_q   <= checksum_d;
    end
  end

endmodule

// File: hdl/serial_frame_receiver_core.sv
// serial_frame_receiver_core: top level, config register and result buffering
// depends on sfr_pkg and sfr_parser
//
// Parses AA 55 | node | type | length | payload | checksum | 0D 0A frames, one
// received byte per item, one item per cycle while tready is high. A completed
// frame gives one result: the phase machine flags it combinationally as its last
// tail byte is accepted; the result register (skid stage on a stall) captures it
// at the accepting edge. A one-entry skid stage behind the result register keeps
// tready high while a result waits; tready drops only when both hold a result.
// Frames with a length above 55 are dropped. The checksum is passed on unchecked.
module serial_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // node_id[7:0], frame_type[15:8], payload_length[21:16], command[29:22],
  // checksum_byte[37:30], zero fill
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import sfr_pkg::*;

  logic [7:0] control_type_q;
  logic       in_accept;
  result_t    res;
  result_t    out_q, out_d;
  result_t    skid_q, skid_d;
  logic       out_free;

  assign s_axis_tready = !skid_q.valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_type_q <= ControlTypeReset;
    end else if (cfg_we_i) begin
      control_type_q <= cfg_wdata_i;
    end
  end

  sfr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_en_i      (in_accept),
    .rx_byte_i      (s_axis_tdata),
    .control_type_i (control_type_q),
    .res_o          (res)
  );

  assign out_free = !out_q.valid || m_axis_tready;

  always_comb begin
    out_d  = out_q;
    skid_d = skid_q;
    if (out_free) begin
      out_d        = skid_q.valid ? skid_q : res;
      skid_d.valid = 1'b0;
    end else if (res.valid) begin
      skid_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else begin
      out_q  <= out_d;
      skid_q <= skid_d;
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = {2'b00, out_q.checksum_byte, out_q.command,
                          out_q.payload_length, out_q.frame_type, out_q.node_id};

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q.valid |-> out_q.valid)
    else $error("skid holds a result while output is empty");

  a_result_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> in_accept)
    else $error("result produced without an accepted item");

  a_no_double_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> !res.valid)
    else $error("two results from consecutive items");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q.valid && !m_axis_tready) |=> skid_q.valid)
    else $error("skid result lost while output stalled");
`endif

endmodule
